FILE: sv/tkf_pkg.sv
// Shared types, constants and saturating helpers of the tilt Kalman filter.
// No dependencies; imported by every module of the block but tkf_queue.
`timescale 1ns / 1ps
package tkf_pkg;

  localparam int TKF_QUEUE_DEPTH = 2;
  localparam int CORDIC_STEPS    = 28;

  localparam logic signed [31:0] PI_Q28  = 32'sd843314857;
  localparam logic signed [63:0] ONE_Q48 = 64'sh0001_0000_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  localparam logic [31:0] TS_RESET = 32'd21474836;
  localparam logic [62:0] QA_RESET = 63'd28147;
  localparam logic [62:0] QB_RESET = 63'd28147;
  localparam logic [62:0] R_RESET  = 63'd28147497671;

  // register indexes
  localparam logic [1:0] REG_TS = 2'd0;
  localparam logic [1:0] REG_QA = 2'd1;
  localparam logic [1:0] REG_QB = 2'd2;
  localparam logic [1:0] REG_R  = 2'd3;

  typedef struct packed {
    logic               go;
    logic               s48;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } tkf_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } tkf_mul_rsp_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] mag,
                                                  input logic ovf);
    if (neg) begin
      if (ovf || mag[63]) return S64_MIN;
      return 64'sd0 - mag;
    end
    if (ovf || mag[63]) return S64_MAX;
    return mag;
  endfunction

  // saturate to Q4.28 and floor-shift by 20
  function automatic logic signed [31:0] narrow(input logic signed [63:0] v);
    logic signed [43:0] t;
    t = v[63:20];
    if (t > 44'sd2147483647) return 32'sh7FFF_FFFF;
    if (t < -44'sd2147483648) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  function automatic logic signed [31:0] atan_tab(input logic [4:0] i);
    case (i)
      5'd0:  return 32'sd210828714;
      5'd1:  return 32'sd124459457;
      5'd2:  return 32'sd65760959;
      5'd3:  return 32'sd33381290;
      5'd4:  return 32'sd16755422;
      5'd5:  return 32'sd8385879;
      5'd6:  return 32'sd4193963;
      5'd7:  return 32'sd2097109;
      5'd8:  return 32'sd1048571;
      5'd9:  return 32'sd524287;
      5'd10: return 32'sd262144;
      5'd11: return 32'sd131072;
      5'd12: return 32'sd65536;
      5'd13: return 32'sd32768;
      5'd14: return 32'sd16384;
      5'd15: return 32'sd8192;
      5'd16: return 32'sd4096;
      5'd17: return 32'sd2048;
      5'd18: return 32'sd1024;
      5'd19: return 32'sd512;
      5'd20: return 32'sd256;
      5'd21: return 32'sd128;
      5'd22: return 32'sd64;
      5'd23: return 32'sd32;
      5'd24: return 32'sd16;
      5'd25: return 32'sd8;
      5'd26: return 32'sd4;
      5'd27: return 32'sd2;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

FILE: sv/tkf_front.sv
// Front end: accepts IMU beats and computes the measured tilt by CORDIC.
// Depends on tkf_pkg; pushes {gyro, angle} into the queue.
`timescale 1ns / 1ps
module tkf_front import tkf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  output logic        q_push,
  output logic [63:0] q_wdata,
  input  logic        q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RUN  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [4:0]         step_r;
  logic signed [31:0] x_r, y_r, z_r, g_r;
  logic               zero_r;

  logic signed [15:0] h, v;
  logic signed [31:0] x0, y0, z0, dx, dy;

  assign in_tready = (state_r == F_IDLE);
  assign q_push    = (state_r == F_PUSH) && !q_full;
  assign q_wdata   = {g_r, zero_r ? 32'sd0 : z_r};

  always_comb begin
    h  = in_tdata[15:0];
    v  = in_tdata[31:16];
    x0 = 32'(v);
    y0 = -32'(h);
    z0 = 32'sd0;
    if (v < 0) begin
      z0 = (h < 0) ? PI_Q28 : -PI_Q28;
      x0 = -x0;
      y0 = -y0;
    end
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE:  if (in_tvalid) state_nxt = F_RUN;
      F_RUN:   if (step_r == 5'(CORDIC_STEPS - 1)) state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE) step_r <= '0;
      else if (state_r == F_RUN) step_r <= step_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_tvalid) begin
      x_r    <= x0 <<< 12;
      y_r    <= y0 <<< 12;
      z_r    <= z0;
      g_r    <= in_tdata[63:32];
      zero_r <= (h == 16'sd0) && (v == 16'sd0);
    end else if (state_r == F_RUN) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_tab(step_r);
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_tab(step_r);
      end
    end
  end

endmodule

FILE: sv/tkf_queue.sv
// Small register FIFO between the CORDIC front end and the filter back end.
// Depends on nothing but its parameters; depth must be a power of two, at least 2.
`timescale 1ns / 1ps
module tkf_queue #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wp_r, rp_r;

  assign valid = (wp_r != rp_r);
  assign full  = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign rdata = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && valid)  rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r[AW-1:0]] <= wdata;
  end

endmodule

FILE: sv/tkf_mul.sv
// Shared saturating 64x64 multiplier: four 32x32 partial products, one a cycle.
// Depends on tkf_pkg; result is (a*b) >> 32 or >> 48, truncated toward zero.
`timescale 1ns / 1ps
module tkf_mul import tkf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  tkf_mul_req_t req,
  output tkf_mul_rsp_t rsp
);

  logic [63:0]  ua_r, ub_r;
  logic         neg_r, s48_r, busy_r, done_r;
  logic [2:0]   cnt_r;
  logic [127:0] acc_r;
  logic signed [63:0] res_r;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] term;
  logic [63:0]  mag;
  logic         ovf;

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  always_comb begin
    pa   = cnt_r[0] ? ua_r[63:32] : ua_r[31:0];
    pb   = cnt_r[1] ? ub_r[63:32] : ub_r[31:0];
    pp   = pa * pb;
    term = {64'd0, pp};
    case (cnt_r[1:0])
      2'd0:    term = {64'd0, pp};
      2'd3:    term = {pp, 64'd0};
      default: term = {32'd0, pp, 32'd0};
    endcase
    if (s48_r) begin
      ovf = (acc_r[127:112] != 16'd0);
      mag = acc_r[111:48];
    end else begin
      ovf = (acc_r[127:96] != 32'd0);
      mag = acc_r[95:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      ua_r  <= mag64(req.a);
      ub_r  <= mag64(req.b);
      neg_r <= req.a[63] ^ req.b[63];
      s48_r <= req.s48;
      acc_r <= '0;
    end else if (busy_r) begin
      if (cnt_r == 3'd4) res_r <= from_mag(neg_r, mag, ovf);
      else acc_r <= acc_r + term;
    end
  end

endmodule

FILE: sv/tkf_back.sv
// Back end: sequences one Kalman step per queued sample over the shared
// multiplier and a bit-serial divider, and holds the result register.
// Depends on tkf_pkg and tkf_mul.
`timescale 1ns / 1ps
module tkf_back import tkf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] ts,
  input  logic [62:0] qa,
  input  logic [62:0] qb,
  input  logic [62:0] rm,
  input  logic        q_valid,
  input  logic [63:0] q_rdata,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_M1   = 5'd1;
  localparam logic [4:0] S_M2   = 5'd2;
  localparam logic [4:0] S_M3   = 5'd3;
  localparam logic [4:0] S_M4   = 5'd4;
  localparam logic [4:0] S_SUM  = 5'd5;
  localparam logic [4:0] S_D0   = 5'd6;
  localparam logic [4:0] S_D1   = 5'd7;
  localparam logic [4:0] S_E    = 5'd8;
  localparam logic [4:0] S_M5   = 5'd9;
  localparam logic [4:0] S_M6   = 5'd10;
  localparam logic [4:0] S_M7   = 5'd11;
  localparam logic [4:0] S_M8   = 5'd12;
  localparam logic [4:0] S_M9   = 5'd13;
  localparam logic [4:0] S_M10  = 5'd14;
  localparam logic [4:0] S_OUT  = 5'd15;

  localparam int DIV_STEPS = 64 + 48;

  logic [4:0] state_r;

  logic signed [31:0] ang_st_r, bia_st_r, meas_r;
  logic signed [63:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [63:0] xm0_r, a_r, b_r, m00_r, m10_r, m11_r, s_r, k0_r, k1_r, e_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  tkf_mul_req_t       mreq;
  logic               mgo_r, ms48_r;
  logic signed [63:0] ma_r, mb_r;
  tkf_mul_rsp_t       mrsp;

  // divider
  logic               dgo_r, dbusy_r, ddone_r, dneg_r, dovf_r;
  logic [63:0]        dn_r, dd_r, dr_r, dq_r;
  logic [6:0]         dcnt_r;
  logic signed [63:0] dres_r, dn_in, dd_in;
  logic [63:0]        r_sh, r_n, q_n;
  logic               ge, ovf_n;

  logic signed [63:0] ts_ext, qa_ext, qb_ext, rm_ext, ang_ext, bia_ext, meas_ext, rate;
  logic signed [63:0] t_s, t_b, t_m00, t_omk, t_e;
  logic               mul_ok;

  assign mreq = '{go: mgo_r, s48: ms48_r, a: ma_r, b: mb_r};

  tkf_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign mul_ok     = mrsp.done;

  always_comb begin
    ts_ext   = {32'd0, ts};
    qa_ext   = {1'b0, qa};
    qb_ext   = {1'b0, qb};
    rm_ext   = {1'b0, rm};
    ang_ext  = {{12{ang_st_r[31]}}, ang_st_r, 20'd0};
    bia_ext  = {{12{bia_st_r[31]}}, bia_st_r, 20'd0};
    meas_ext = {{12{meas_r[31]}}, meas_r, 20'd0};
    rate     = {{8{q_rdata[63]}}, q_rdata[63:32], 24'd0};
    t_b      = ssub(p01_r, mrsp.res);
    t_m00    = sadd(ssub(a_r, mrsp.res), qa_ext);
    t_s      = sadd(m00_r, rm_ext);
    t_omk    = ssub(ONE_Q48, k0_r);
    t_e      = ssub(meas_ext, xm0_r);
  end

  always_comb begin
    r_sh  = {dr_r[62:0], dn_r[63]};
    ge    = (r_sh >= dd_r);
    r_n   = ge ? (r_sh - dd_r) : r_sh;
    q_n   = {dq_r[62:0], ge};
    ovf_n = dovf_r | dq_r[63];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      ddone_r <= 1'b0;
      if (dgo_r) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 7'd1;
        if (dcnt_r == 7'(DIV_STEPS - 1)) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dgo_r) begin
      dn_r   <= mag64(dn_in);
      dd_r   <= dd_in;
      dneg_r <= dn_in[63];
      dr_r   <= '0;
      dq_r   <= '0;
      dovf_r <= 1'b0;
    end else if (dbusy_r) begin
      dn_r   <= {dn_r[62:0], 1'b0};
      dr_r   <= r_n;
      dq_r   <= q_n;
      dovf_r <= ovf_n;
      if (dcnt_r == 7'(DIV_STEPS - 1)) dres_r <= from_mag(dneg_r, q_n, ovf_n);
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mgo_r       <= 1'b0;
      dgo_r       <= 1'b0;
    end else begin
      mgo_r <= 1'b0;
      dgo_r <= 1'b0;
      if (out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          mgo_r   <= 1'b1;
          state_r <= S_M1;
        end
        S_M1:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M2; end
        S_M2:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M3; end
        S_M3:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M4; end
        S_M4:  if (mul_ok) state_r <= S_SUM;
        S_SUM: begin
          if (!t_s[63] && t_s != 64'sd0) begin
            dgo_r   <= 1'b1;
            state_r <= S_D0;
          end else begin
            state_r <= S_E;
          end
        end
        S_D0:  if (ddone_r) begin dgo_r <= 1'b1; state_r <= S_D1; end
        S_D1:  if (ddone_r) state_r <= S_E;
        S_E:   begin mgo_r <= 1'b1; state_r <= S_M5; end
        S_M5:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M6; end
        S_M6:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M7; end
        S_M7:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M8; end
        S_M8:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M9; end
        S_M9:  if (mul_ok) begin mgo_r <= 1'b1; state_r <= S_M10; end
        S_M10: if (mul_ok) state_r <= S_OUT;
        S_OUT: if (!out_valid_r || out_tready) begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // divider operands
  always_comb begin
    dn_in = m00_r;
    dd_in = t_s;
    if (state_r == S_D1) begin
      dn_in = m10_r;
      dd_in = s_r;
    end
  end

  // filter datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_st_r <= '0;
      bia_st_r <= '0;
      p00_r    <= ONE_Q48;
      p01_r    <= '0;
      p10_r    <= '0;
      p11_r    <= ONE_Q48;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          meas_r <= q_rdata[31:0];
          ma_r   <= ts_ext;
          mb_r   <= ssub(rate, bia_ext);
          ms48_r <= 1'b0;
        end
        S_M1: if (mul_ok) begin
          xm0_r <= sadd(ang_ext, mrsp.res);
          mb_r  <= p10_r;
        end
        S_M2: if (mul_ok) begin
          a_r  <= ssub(p00_r, mrsp.res);
          mb_r <= p11_r;
        end
        S_M3: if (mul_ok) begin
          b_r   <= t_b;
          m10_r <= ssub(p10_r, mrsp.res);
          mb_r  <= t_b;
        end
        S_M4: if (mul_ok) begin
          m00_r <= t_m00;
          m11_r <= sadd(p11_r, qb_ext);
        end
        S_SUM: begin
          s_r  <= t_s;
          k0_r <= '0;
          k1_r <= '0;
        end
        S_D0: if (ddone_r) k0_r <= dres_r;
        S_D1: if (ddone_r) k1_r <= dres_r;
        S_E: begin
          e_r    <= t_e;
          ma_r   <= k0_r;
          mb_r   <= t_e;
          ms48_r <= 1'b1;
        end
        S_M5: if (mul_ok) begin
          ang_st_r <= narrow(sadd(xm0_r, mrsp.res));
          ma_r     <= k1_r;
          mb_r     <= e_r;
        end
        S_M6: if (mul_ok) begin
          bia_st_r <= narrow(sadd(bia_ext, mrsp.res));
          ma_r     <= t_omk;
          mb_r     <= m00_r;
        end
        S_M7: if (mul_ok) begin
          p00_r <= mrsp.res;
          mb_r  <= b_r;
        end
        S_M8: if (mul_ok) begin
          p01_r <= mrsp.res;
          ma_r  <= k1_r;
          mb_r  <= m00_r;
        end
        S_M9: if (mul_ok) begin
          p10_r <= ssub(m10_r, mrsp.res);
          mb_r  <= b_r;
        end
        S_M10: if (mul_ok) p11_r <= ssub(m11_r, mrsp.res);
        S_OUT: if (!out_valid_r || out_tready) out_data_r <= {bia_st_r, ang_st_r};
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/tilt_kalman_filter_top.sv
// Tilt Kalman filter top level: APB register file, CORDIC front end, queue
// and filter back end. Depends on tkf_pkg, tkf_front, tkf_queue, tkf_back.
// The back end takes a new sample from the queue only once its last one is done;
// its pace is set by the bit-serial divider (two 112-step quotients) and ten
// passes through the shared multiplier. Reset (synchronous, rst_n low) restores
// register defaults, zero angle and bias, unit diagonal covariance.
`timescale 1ns / 1ps
module tilt_kalman_filter_top import tkf_pkg::*; #(
  parameter int QUEUE_DEPTH = TKF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: accel_horizontal[15:0], accel_vertical[31:16], gyro_rate[63:32]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // out_tdata: angle_estimate[31:0], bias_estimate[63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] ts_r;
  logic [62:0] qa_r, qb_r, rm_r;
  logic [1:0]  idx;
  logic        wr_en;

  logic        q_push, q_full, q_pop, q_valid;
  logic [63:0] q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[4:3];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Registers sit at 8-byte strides; drop value bits above each register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= TS_RESET;
      qa_r <= QA_RESET;
      qb_r <= QB_RESET;
      rm_r <= R_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_TS:  ts_r <= cfg_pwdata[31:0];
        REG_QA:  qa_r <= cfg_pwdata[62:0];
        REG_QB:  qb_r <= cfg_pwdata[62:0];
        REG_R:   rm_r <= cfg_pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TS:  cfg_prdata = {32'd0, ts_r};
      REG_QA:  cfg_prdata = {1'b0, qa_r};
      REG_QB:  cfg_prdata = {1'b0, qb_r};
      REG_R:   cfg_prdata = {1'b0, rm_r};
      default: cfg_prdata = '0;
    endcase
  end

  // Front end: accept a beat, run the 28-step CORDIC, hold until the queue has room.
  tkf_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_push(q_push), .q_wdata(q_wdata), .q_full(q_full)
  );

  // Queue decouples the two halves so the CORDIC may work ahead of the filter.
  tkf_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(64)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .wdata(q_wdata), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .valid(q_valid)
  );

  // Back end: predict, gain, correct; result beat held in its output register.
  tkf_back u_back (
    .clk(clk), .rst_n(rst_n),
    .ts(ts_r), .qa(qa_r), .qb(qb_r), .rm(rm_r),
    .q_valid(q_valid), .q_rdata(q_rdata), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
